/* rtl/mgkr_pkg.sv */
// Shared types, key codes and lookup functions for the modifier-gated key remapper.
// No dependencies; used by every rtl file of the block.
package mgkr_pkg;

   localparam int TYPE_W  = 5;
   localparam int CODE_W  = 10;
   localparam int VALUE_W = 32;
   localparam int MASK_W  = 4;

   localparam logic [TYPE_W-1:0] EV_KEY = TYPE_W'(1);

   localparam logic [VALUE_W-1:0] KEY_RELEASE = VALUE_W'(0);
   localparam logic [VALUE_W-1:0] KEY_PRESS   = VALUE_W'(1);

   localparam logic [CODE_W-1:0] KEY_LEFTCTRL  = CODE_W'(29);
   localparam logic [CODE_W-1:0] KEY_RIGHTCTRL = CODE_W'(97);
   localparam logic [CODE_W-1:0] KEY_LEFTALT   = CODE_W'(56);
   localparam logic [CODE_W-1:0] KEY_LEFTMETA  = CODE_W'(125);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   function automatic logic [MASK_W-1:0] mod_bit_of(input logic [CODE_W-1:0] k);
      logic [MASK_W-1:0] r;
      begin
         case (k)
            KEY_LEFTCTRL:  r = 4'b0001;
            KEY_RIGHTCTRL: r = 4'b0010;
            KEY_LEFTALT:   r = 4'b0100;
            KEY_LEFTMETA:  r = 4'b1000;
            default:       r = 4'b0000;
         endcase
         return r;
      end
   endfunction

   // fixed remap table; codes not listed map to themselves
   function automatic logic [CODE_W-1:0] remap_of(input logic [CODE_W-1:0] k);
      logic [CODE_W-1:0] r;
      begin
         case (k)
            10'd12: r = 10'd40;  10'd13: r = 10'd27;  10'd16: r = 10'd45;
            10'd17: r = 10'd51;  10'd18: r = 10'd32;  10'd19: r = 10'd24;
            10'd20: r = 10'd37;  10'd21: r = 10'd20;  10'd22: r = 10'd33;
            10'd23: r = 10'd34;  10'd24: r = 10'd31;  10'd25: r = 10'd19;
            10'd26: r = 10'd12;  10'd27: r = 10'd13;  10'd30: r = 10'd30;
            10'd31: r = 10'd39;  10'd32: r = 10'd35;  10'd33: r = 10'd21;
            10'd34: r = 10'd22;  10'd35: r = 10'd36;  10'd36: r = 10'd46;
            10'd37: r = 10'd47;  10'd38: r = 10'd25;  10'd39: r = 10'd44;
            10'd40: r = 10'd16;  10'd44: r = 10'd53;  10'd45: r = 10'd48;
            10'd46: r = 10'd23;  10'd47: r = 10'd52;  10'd48: r = 10'd49;
            10'd49: r = 10'd38;  10'd50: r = 10'd50;  10'd51: r = 10'd17;
            10'd52: r = 10'd18;  10'd53: r = 10'd26;
            default: r = k;
         endcase
         return r;
      end
   endfunction

endpackage

/* rtl/modifier_gated_key_remapper.sv */
// Top level of the modifier-gated key remapper: sequencer, compare unit and stream ports.
// Depends on mgkr_pkg and mgkr_held_list.
//
// One event in, one event out. Key events (type 1, value 0..3) track a 4-bit modifier
// mask (left-ctrl, right-ctrl, left-alt, win). A key with a remap entry is remapped while
// a modifier is held or remapped keys are still down: a press appends code+1 to the
// held-key list (LIST_DEPTH entries; when full the key passes unmapped with the warning
// flag set), a release clears every matching entry, emits the mapped code if any matched,
// and trims trailing empty slots from the count. A press or any other event goes through
// the decide and finish states; a remapped release walks the used part of the list with
// one comparator, one entry per cycle through the list's single read port. req_tready
// comes back in the cycle the result appears; a previous result still waiting on
// rsp_tready holds the block in its finish state. The result register lets the next
// event be accepted while the previous result waits. No clearing pass after reset.
module modifier_gated_key_remapper
   import mgkr_pkg::*;
#(
   parameter int LIST_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // [9:0] key_code, [41:10] event_value, [47:42] zero
   input  logic [4:0]  req_tuser,  // [4:0] event_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [9:0] out_code, [41:10] out_value, [47:42] zero
   output logic [5:0]  rsp_tuser   // [4:0] out_type, [5] list_full_warning
);

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

   state_type state_ff, state_in;

   logic [TYPE_W-1:0]  type_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [CODE_W-1:0]  mapped_ff, mapped_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   newcount_ff, newcount_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               found_ff, found_in;
   logic [CODE_W-1:0]  res_code_ff, res_code_in;
   logic               warn_ff, warn_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TYPE_W-1:0]  rsp_type_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_warn_ff;
   logic               rsp_load;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [CODE_W-1:0]  wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [CODE_W-1:0]  rd_data;

   logic               is_key;
   logic [MASK_W-1:0]  mb;
   logic [CODE_W-1:0]  mapped;
   logic [MASK_W-1:0]  next_mask;
   logic               remap_ok;
   logic [CODE_W-1:0]  tag;
   logic               req_beat;

   mgkr_held_list #(
      .DEPTH  (LIST_DEPTH),
      .ADDR_W (IDX_W)
   ) u_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign tag        = code_ff + CODE_W'(1);

   assign is_key    = (type_ff == EV_KEY) && (value_ff[VALUE_W-1:2] == '0);
   assign mb        = mod_bit_of(code_ff);
   assign mapped    = remap_of(code_ff);
   assign next_mask = (value_ff == KEY_PRESS)   ? (mask_ff | mb) :
                      (value_ff == KEY_RELEASE) ? (mask_ff & ~mb) : mask_ff;
   assign remap_ok  = (mapped != code_ff) && ((next_mask != '0) || (count_ff != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         type_ff  <= req_tuser[TYPE_W-1:0];
         code_ff  <= req_tdata[CODE_W-1:0];
         value_ff <= req_tdata[CODE_W +: VALUE_W];
      end
      mapped_ff   <= mapped_in;
      idx_ff      <= idx_in;
      newcount_ff <= newcount_in;
      cmp_idx_ff  <= cmp_idx_in;
      found_ff    <= found_in;
      res_code_ff <= res_code_in;
      warn_ff     <= warn_in;
      if (rsp_load) begin
         rsp_type_ff  <= type_ff;
         rsp_code_ff  <= res_code_ff;
         rsp_value_ff <= value_ff;
         rsp_warn_ff  <= warn_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;
      mapped_in    = mapped_ff;
      idx_in       = idx_ff;
      newcount_in  = newcount_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      res_code_in  = res_code_ff;
      warn_in      = warn_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = tag;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[IDX_W-1:0];
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_code_in = code_ff;
            warn_in     = 1'b0;
            mapped_in   = mapped;
            state_in    = ST_FINISH;
            if (is_key) begin
               mask_in = next_mask;
               if (remap_ok && value_ff == KEY_PRESS) begin
                  if (count_ff >= DEPTH_CNT) begin
                     warn_in = 1'b1;
                  end else begin
                     wr_en       = 1'b1;
                     count_in    = count_ff + CNT_W'(1);
                     res_code_in = mapped;
                  end
               end else if (remap_ok && value_ff == KEY_RELEASE) begin
                  idx_in      = '0;
                  newcount_in = '0;
                  found_in    = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read entry idx while comparing the entry read last cycle
            if (idx_ff < count_ff) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = idx_ff[IDX_W-1:0];
               idx_in       = idx_ff + CNT_W'(1);
            end
            if (cmp_valid_ff) begin
               if (rd_data == tag) begin
                  wr_en    = 1'b1;
                  wr_addr  = cmp_idx_ff;
                  wr_data  = '0;
                  found_in = 1'b1;
               end else if (rd_data != '0) begin
                  newcount_in = CNT_W'({1'b0, cmp_idx_ff}) + CNT_W'(1);
               end
            end else if (!(idx_ff < count_ff)) begin
               count_in    = newcount_ff;
               res_code_in = found_ff ? mapped_ff : code_ff;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_value_ff, rsp_code_ff};
   assign rsp_tuser  = {rsp_warn_ff, rsp_type_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("held key count above list depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff > $past(count_ff) |-> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("held key count grew by more than one");

   a_warn_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && warn_ff |-> count_ff == DEPTH_CNT)
      else $error("list full warning with free list slots");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (state_ff == ST_SCAN) && (CNT_W'({1'b0, cmp_idx_ff}) < count_ff))
      else $error("list compare outside used entries");

endmodule

/* rtl/mgkr_held_list.sv */
// Held-key list storage: one write port, one registered read port.
// Depends on mgkr_pkg for the code width.
module mgkr_held_list
   import mgkr_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CODE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CODE_W-1:0] rd_data
);

   logic [CODE_W-1:0] mem [DEPTH];
   logic [CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sim/tb_modifier_gated_key_remapper.sv */
// Self-checking testbench for modifier_gated_key_remapper: directed table, then random typing,
// list-fill and noise bursts, with an in-bench key remap predictor. Depends on mgkr_pkg.
`timescale 1ns / 100ps

module tb_modifier_gated_key_remapper;
   import mgkr_pkg::*;

   localparam int LIST_DEPTH     = 32;
   localparam int NUM_EVENTS     = 650;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [VALUE_W-1:0] KEY_REPEAT = VALUE_W'(2);
   localparam logic [TYPE_W-1:0]  EV_SYN     = TYPE_W'(0);
   localparam logic [TYPE_W-1:0]  EV_TOP     = TYPE_W'(31);

   typedef struct packed {
      logic        warn;
      logic [31:0] value;
      logic [9:0]  code;
      logic [4:0]  ev_type;
   } key_result_type;

   typedef struct packed {
      logic [4:0]  ev_type;
      logic [9:0]  code;
      logic [31:0] value;
      logic        typed;
      logic [9:0]  exp_code;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // [9:0] key_code, [41:10] event_value, [47:42] zero
   logic [4:0]  req_tuser;   // [4:0] event_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [9:0] out_code, [41:10] out_value, [47:42] zero
   logic [5:0]  rsp_tuser;   // [4:0] out_type, [5] list_full_warning

   // predictor state
   logic [3:0]  mod_mask;
   logic [9:0]  held_keys [LIST_DEPTH];
   int unsigned held_cnt;
   logic [9:0]  swap_to [64];
   logic [9:0]  mod_keys [4];

   key_result_type out_event_q [$];
   stim_row_type   directed_q [$];

   bit calm;
   int errors, events_sent, events_checked, remaps, full_warnings, idle_cycles;

   modifier_gated_key_remapper #(.LIST_DEPTH(LIST_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic key_result_type remap_event(input logic [4:0] t, input logic [9:0] c,
                                                  input logic [31:0] v);
      key_result_type r;
      logic [3:0]     mb;
      logic [9:0]     tgt;
      r.ev_type = t;
      r.code    = c;
      r.value   = v;
      r.warn    = 1'b0;
      if (t == EV_KEY && v <= KEY_REPEAT) begin
         mb = 4'b0000;
         for (int i = 0; i < 4; i++)
            if (c == mod_keys[i]) mb[i] = 1'b1;
         tgt = (c < 64) ? swap_to[c] : c;
         if (v == KEY_PRESS) mod_mask = mod_mask | mb;
         else if (v == KEY_RELEASE) mod_mask = mod_mask & ~mb;
         if (tgt != c && (mod_mask != 0 || held_cnt != 0)) begin
            if (v == KEY_PRESS) begin
               if (held_cnt >= LIST_DEPTH) begin
                  r.warn = 1'b1;
               end else begin
                  held_keys[held_cnt] = c + 10'd1;
                  held_cnt++;
                  r.code = tgt;
               end
            end else if (v == KEY_RELEASE) begin
               for (int i = 0; i < held_cnt; i++)
                  if (held_keys[i] == c + 10'd1) begin
                     held_keys[i] = '0;
                     r.code = tgt;
                  end
               while (held_cnt > 0 && held_keys[held_cnt-1] == 0) held_cnt--;
            end
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [9:0] pick_mapped_key();
      logic [9:0] k;
      k = 10'($urandom_range(12, 53));
      while (swap_to[k] == k) k = 10'($urandom_range(12, 53));
      return k;
   endfunction

   function automatic logic [9:0] pick_key();
      logic [9:0] k;
      if ($urandom_range(0, 4) != 0) k = pick_mapped_key();
      else k = 10'($urandom_range(0, 127));
      return k;
   endfunction

   // entered and left at a falling edge
   task automatic send_event(input logic [4:0] t, input logic [9:0] c, input logic [31:0] v,
                             input logic typed, input logic [9:0] typed_code);
      int             gap;
      key_result_type exp_ev;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= t;
      req_tdata  <= {6'd0, v, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      exp_ev = remap_event(t, c, v);
      if (typed) begin
         exp_ev.code = typed_code;
         exp_ev.warn = 1'b0;
      end
      if (exp_ev.code != c) remaps++;
      if (exp_ev.warn) full_warnings++;
      out_event_q.push_back(exp_ev);
      events_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (out_event_q.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic [4:0] t, input logic [9:0] c, input logic [31:0] v,
                          input logic typed, input logic [9:0] exp_code);
      stim_row_type row;
      row.ev_type  = t;
      row.code     = c;
      row.value    = v;
      row.typed    = typed;
      row.exp_code = exp_code;
      directed_q.push_back(row);
   endtask

   task automatic release_all();
      while (held_cnt != 0)
         send_event(EV_KEY, held_keys[held_cnt-1] - 10'd1, KEY_RELEASE, 1'b0, '0);
      for (int i = 0; i < 4; i++)
         if (mod_mask[i]) send_event(EV_KEY, mod_keys[i], KEY_RELEASE, 1'b0, '0);
   endtask

   task automatic typing_burst();
      logic [9:0] mod_key;
      logic [9:0] down [$];
      bit         use_mod, early;
      int         idx;
      use_mod = ($urandom_range(0, 3) != 0);
      early   = 1'($urandom_range(0, 1));
      mod_key = mod_keys[$urandom_range(0, 3)];
      if (use_mod) send_event(EV_KEY, mod_key, KEY_PRESS, 1'b0, '0);
      repeat ($urandom_range(1, 6)) begin
         down.push_back(pick_key());
         send_event(EV_KEY, down[$], KEY_PRESS, 1'b0, '0);
         if ($urandom_range(0, 3) == 0) send_event(EV_KEY, down[$], KEY_REPEAT, 1'b0, '0);
      end
      if (use_mod && early) send_event(EV_KEY, mod_key, KEY_RELEASE, 1'b0, '0);
      while (down.size() != 0) begin
         idx = $urandom_range(0, down.size() - 1);
         send_event(EV_KEY, down[idx], KEY_RELEASE, 1'b0, '0);
         down.delete(idx);
      end
      if (use_mod && !early) send_event(EV_KEY, mod_key, KEY_RELEASE, 1'b0, '0);
   endtask

   // runs from just under to past the list depth so presses may spill over with the warning
   task automatic fill_list();
      send_event(EV_KEY, mod_keys[$urandom_range(0, 3)], KEY_PRESS, 1'b0, '0);
      repeat ($urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 4))
         send_event(EV_KEY, pick_mapped_key(), KEY_PRESS, 1'b0, '0);
      if ($urandom_range(0, 1)) send_event(EV_KEY, pick_mapped_key(), KEY_REPEAT, 1'b0, '0);
      if ($urandom_range(0, 1)) send_event(EV_KEY, pick_mapped_key(), KEY_RELEASE, 1'b0, '0);
      release_all();
   endtask

   task automatic noise_burst();
      logic [4:0]  t;
      logic [9:0]  c;
      logic [31:0] v;
      repeat ($urandom_range(1, 4)) begin
         t = $urandom_range(0, 1) ? EV_KEY : 5'($urandom_range(0, 31));
         c = 10'($urandom_range(0, 767));
         v = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 2));
         send_event(t, c, v, 1'b0, '0);
      end
      if ($urandom_range(0, 3) == 0) release_all();
   endtask

   // result checker
   always @(posedge clock) begin
      key_result_type act, exp_ev;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act = {rsp_tuser[5], rsp_tdata[41:10], rsp_tdata[9:0], rsp_tuser[4:0]};
         events_checked++;
         if (out_event_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, type %0d code %0d value %0d warn %0d", $time,
                     act.ev_type, act.code, $signed(act.value), act.warn);
         end else begin
            exp_ev = out_event_q.pop_front();
            if (act !== exp_ev || rsp_tdata[47:42] !== 6'd0) begin
               errors++;
               $display("%0t: expected type %0d code %0d value %0d warn %0d pad 0, got %s",
                        $time, exp_ev.ev_type, exp_ev.code, $signed(exp_ev.value),
                        exp_ev.warn,
                        $sformatf("type %0d code %0d value %0d warn %0d pad %0d",
                                  act.ev_type, act.code, $signed(act.value), act.warn,
                                  rsp_tdata[47:42]));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no beat for %0d cycles, %0d results pending", $time,
                  idle_cycles, out_event_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // result-side backpressure
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         int stall;
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   initial begin
      int r;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      calm        = 1'b0;
      mod_mask    = '0;
      held_cnt    = 0;
      idle_cycles = 0;
      for (int i = 0; i < LIST_DEPTH; i++) held_keys[i] = '0;
      for (int i = 0; i < 64; i++) swap_to[i] = 10'(i);
      swap_to[12] = 40; swap_to[13] = 27; swap_to[16] = 45; swap_to[17] = 51;
      swap_to[18] = 32; swap_to[19] = 24; swap_to[20] = 37; swap_to[21] = 20;
      swap_to[22] = 33; swap_to[23] = 34; swap_to[24] = 31; swap_to[25] = 19;
      swap_to[26] = 12; swap_to[27] = 13; swap_to[31] = 39; swap_to[32] = 35;
      swap_to[33] = 21; swap_to[34] = 22; swap_to[35] = 36; swap_to[36] = 46;
      swap_to[37] = 47; swap_to[38] = 25; swap_to[39] = 44; swap_to[40] = 16;
      swap_to[44] = 53; swap_to[45] = 48; swap_to[46] = 23; swap_to[47] = 52;
      swap_to[48] = 49; swap_to[49] = 38; swap_to[51] = 17; swap_to[52] = 18;
      swap_to[53] = 26;
      mod_keys[0] = KEY_LEFTCTRL;
      mod_keys[1] = KEY_RIGHTCTRL;
      mod_keys[2] = KEY_LEFTALT;
      mod_keys[3] = KEY_LEFTMETA;

      add_row(EV_KEY, 10'd12,   KEY_PRESS,     1'b1, 10'd12);   // no modifier, empty list
      add_row(EV_SYN, 10'd0,    32'd0,         1'b1, 10'd0);
      add_row(EV_TOP, 10'd767,  32'h7FFF_FFFF, 1'b1, 10'd767);
      add_row(EV_KEY, KEY_LEFTCTRL, 32'h8000_0000, 1'b1, KEY_LEFTCTRL);
      add_row(EV_KEY, 10'd12,   KEY_RELEASE,   1'b1, 10'd12);
      add_row(EV_KEY, KEY_LEFTCTRL, KEY_PRESS, 1'b1, KEY_LEFTCTRL);
      add_row(EV_KEY, 10'd12,   KEY_PRESS,     1'b0, '0);
      add_row(EV_KEY, 10'd12,   KEY_REPEAT,    1'b0, '0);
      add_row(EV_KEY, 10'd30,   KEY_PRESS,     1'b0, '0);       // identity entries
      add_row(EV_KEY, 10'd50,   KEY_PRESS,     1'b0, '0);
      add_row(EV_KEY, KEY_LEFTCTRL, KEY_RELEASE, 1'b0, '0);
      add_row(EV_KEY, 10'd16,   KEY_PRESS,     1'b0, '0);       // held list alone gates
      add_row(EV_KEY, 10'd13,   KEY_RELEASE,   1'b0, '0);       // release not in list
      add_row(EV_KEY, 10'd12,   KEY_RELEASE,   1'b0, '0);
      add_row(EV_KEY, 10'd16,   KEY_RELEASE,   1'b0, '0);
      add_row(EV_KEY, KEY_RIGHTCTRL, KEY_PRESS, 1'b0, '0);
      add_row(EV_KEY, KEY_LEFTALT,   KEY_PRESS, 1'b0, '0);
      add_row(EV_KEY, KEY_LEFTMETA,  KEY_PRESS, 1'b0, '0);
      add_row(EV_KEY, 10'd53,   KEY_PRESS,     1'b0, '0);       // duplicate entries
      add_row(EV_KEY, 10'd53,   KEY_PRESS,     1'b0, '0);
      add_row(EV_KEY, 10'd53,   KEY_RELEASE,   1'b0, '0);
      add_row(EV_KEY, KEY_RIGHTCTRL, KEY_RELEASE, 1'b0, '0);
      add_row(EV_KEY, KEY_LEFTALT,   KEY_RELEASE, 1'b0, '0);
      add_row(EV_KEY, KEY_LEFTMETA,  KEY_RELEASE, 1'b0, '0);
      add_row(EV_KEY, 10'd767,  KEY_PRESS,     1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_q[i])
         send_event(directed_q[i].ev_type, directed_q[i].code, directed_q[i].value,
                    directed_q[i].typed, directed_q[i].exp_code);
      wait_for_drain();

      while (events_sent < NUM_EVENTS) begin
         calm = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 9);
         if (r <= 5) begin
            typing_burst();
         end else if (r <= 7) begin
            noise_burst();
         end else if (r == 8) begin
            fill_list();
         end else begin
            wait_for_drain();
            typing_burst();
         end
      end
      req_tvalid <= 1'b0;

      while (out_event_q.size() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 20) @(posedge clock);

      $display("Sent %0d events (directed, typing, list-fill, noise); checked %0d results.",
               events_sent, events_checked);
      $display("Remapped %0d codes, %0d list-full warnings, %0d mismatches.",
               remaps, full_warnings, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
